FILE: sv/ifd_pkg.sv
package ifd_pkg;

    localparam int MAX_PAYLOAD_DEF = 512;

    localparam logic [7:0]  SYNC_A        = 8'h5A;
    localparam logic [7:0]  SYNC_B        = 8'hA5;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [7:0]  FIXED_TAG     = 8'h91;
    localparam int          FIXED_MIN_LEN = 76;
    localparam logic [9:0]  TALLY_MAX     = 10'd1023;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LENLO   = 3'd2,
        PH_LENHI   = 3'd3,
        PH_CRCLO   = 3'd4,
        PH_CRCHI   = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_FIXED   = 3'd1,
        ST_LEGACY  = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_CRC_ERR = 3'd4,
        ST_LEN_ERR = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0] frame_phase;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [8:0] byte_offset;
        logic       frame_end;
        logic [2:0] frame_status;
        logic [9:0] frame_length;
        logic       sync_found;
        logic [9:0] unknown_items;
    } result_t;

    typedef struct packed {
        logic clear;
        logic step;
    } tlv_ctl_t;

    typedef struct packed {
        logic [4:0] size;
        logic       data;
    } tag_info_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    localparam logic [15:0] SYNC_CRC = crc_byte(crc_byte(16'h0000, SYNC_A), SYNC_B);

    function automatic tag_info_t tag_lookup(input logic [7:0] tag);
        tag_info_t t;
        t.data = 1'b1;
        case (tag) inside
            8'h90: t.size = 5'd2;
            8'hA0, 8'hA1, 8'hA2, 8'hA5, 8'hB0, 8'hB1, 8'hB2,
            8'hC0, 8'hC1, 8'hC2, 8'hD0: t.size = 5'd7;
            8'hD9: t.size = 5'd13;
            8'hD1: t.size = 5'd17;
            8'hE0, 8'hF0:
            begin
                t.size = 5'd5;
                t.data = 1'b0;
            end
            default:
            begin
                t.size = 5'd0;
                t.data = 1'b0;
            end
        endcase
        return t;
    endfunction

endpackage

FILE: sv/ifd_in_if.sv
interface ifd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: sv/ifd_out_if.sv
interface ifd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] frame_phase;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [8:0] byte_offset;
    logic       frame_end;
    logic [2:0] frame_status;
    logic [9:0] frame_length;
    logic       sync_found;
    logic [9:0] unknown_items;

    modport source (
        output valid, output frame_phase, output payload_valid, output payload_byte,
        output byte_offset, output frame_end, output frame_status,
        output frame_length, output sync_found, output unknown_items,
        input ready
    );
    modport sink (
        input valid, input frame_phase, input payload_valid, input payload_byte,
        input byte_offset, input frame_end, input frame_status,
        input frame_length, input sync_found, input unknown_items,
        output ready
    );
endinterface

FILE: sv/ifd_tlv.sv
module ifd_tlv
    import ifd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tlv_ctl_t   ctl,
    input  logic [7:0] tag,
    output logic       seen_next,
    output logic [9:0] tally_next
);

    logic [4:0] left_reg;
    logic [4:0] left_next;
    logic       carries_reg;
    logic       carries_next;
    logic       seen_reg;
    logic [9:0] tally_reg;
    tag_info_t  info;

    always_comb
    begin
        info         = tag_lookup(tag);
        left_next    = left_reg;
        carries_next = carries_reg;
        seen_next    = seen_reg;
        tally_next   = tally_reg;
        if (ctl.clear)
        begin
            left_next    = '0;
            carries_next = 1'b0;
            seen_next    = 1'b0;
            tally_next   = '0;
        end
        else if (ctl.step)
        begin
            if (left_reg == 5'd0)
            begin
                if (info.size == 5'd0)
                begin
                    if (tally_reg != TALLY_MAX)
                    begin
                        tally_next = tally_reg + 10'd1;
                    end
                end
                else
                begin
                    left_next    = info.size - 5'd1;
                    carries_next = info.data;
                end
            end
            else
            begin
                left_next = left_reg - 5'd1;
                if (left_reg == 5'd1 && carries_reg)
                begin
                    seen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg    <= '0;
            carries_reg <= 1'b0;
            seen_reg    <= 1'b0;
            tally_reg   <= '0;
        end
        else
        begin
            left_reg    <= left_next;
            carries_reg <= carries_next;
            seen_reg    <= seen_next;
            tally_reg   <= tally_next;
        end
    end

endmodule

FILE: sv/imu_frame_deframer_crc16.sv
// byte-serial deframer for sync-headed sensor frames with crc-16 check
// din: one received byte per item (rx_byte), valid/ready handshake
// dout: one result item per input item: phase after the byte, payload
//   byte with its offset, frame verdict with length and unknown tag count
// frames: 0x5a 0xa5 sync, little-endian length, little-endian crc, payload
// crc-16 (poly 0x1021, init 0) covers sync, length and payload
// result: registered, offered in the cycle after its byte is accepted
// throughput: one byte per cycle while dout.ready is high; the unrolled 8-bit
//   crc update and the tlv item walker both finish in the cycle the byte is accepted
// stall: the result register holds while dout.ready is low; din.ready
//   stays high as long as the result register is empty or being drained
// reset: phase returns to sync hunt, all frame state clears, no result
//   is pending
module imu_frame_deframer_crc16
    import ifd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    ifd_in_if.sink    din,
    ifd_out_if.source dout
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [7:0]         len_lo_reg;
    logic [7:0]         len_lo_next;
    logic [LEN_W-1:0]   plen_reg;
    logic [LEN_W-1:0]   plen_next;
    logic [15:0]        exp_crc_reg;
    logic [15:0]        exp_crc_next;
    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic [LEN_W-1:0]   count_reg;
    logic [LEN_W-1:0]   count_next;
    logic               fixed_reg;
    logic               fixed_next;
    logic               out_valid_reg;
    result_t            res_reg;
    result_t            res_next;

    logic               accept;
    logic [15:0]        crc_upd;
    logic [15:0]        len16;
    logic               len_bad;
    tlv_ctl_t           tlv_ctl;
    logic               tlv_seen;
    logic [9:0]         tlv_tally;
    logic [7:0]         b;

    assign b        = din.rx_byte;
    assign din.ready = !out_valid_reg || dout.ready;
    assign accept   = din.valid && din.ready;
    assign crc_upd  = crc_byte(crc_reg, b);
    assign len16    = {b, len_lo_reg};
    assign len_bad  = (len16 == 16'd0) || (17'(len16) > 17'(MAX_PAYLOAD));

    ifd_tlv u_tlv (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tlv_ctl),
        .tag        (b),
        .seen_next  (tlv_seen),
        .tally_next (tlv_tally)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        len_lo_next   = len_lo_reg;
        plen_next     = plen_reg;
        exp_crc_next  = exp_crc_reg;
        crc_next      = crc_reg;
        count_next    = count_reg;
        fixed_next    = fixed_reg;
        tlv_ctl.clear = 1'b0;
        tlv_ctl.step  = 1'b0;
        res_next      = '0;
        case (phase_reg)
            PH_SYNC1:
            begin
                if (b == SYNC_A)
                begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (b == SYNC_B)
                begin
                    res_next.sync_found = 1'b1;
                    crc_next            = SYNC_CRC;
                    phase_next          = PH_LENLO;
                end
                else if (b != SYNC_A)
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_LENLO:
            begin
                len_lo_next = b;
                crc_next    = crc_upd;
                phase_next  = PH_LENHI;
            end
            PH_LENHI:
            begin
                if (len_bad)
                begin
                    res_next.frame_end    = 1'b1;
                    res_next.frame_status = ST_LEN_ERR;
                    res_next.frame_length = (len16 > 16'(TALLY_MAX)) ? TALLY_MAX : len16[9:0];
                    phase_next            = PH_SYNC1;
                end
                else
                begin
                    plen_next  = len16[LEN_W-1:0];
                    crc_next   = crc_upd;
                    phase_next = PH_CRCLO;
                end
            end
            PH_CRCLO:
            begin
                exp_crc_next = {8'h00, b};
                phase_next   = PH_CRCHI;
            end
            PH_CRCHI:
            begin
                exp_crc_next  = {b, exp_crc_reg[7:0]};
                count_next    = '0;
                fixed_next    = 1'b0;
                tlv_ctl.clear = 1'b1;
                phase_next    = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = b;
                res_next.byte_offset   = 9'(count_reg);
                if (count_reg == '0 && b == FIXED_TAG)
                begin
                    fixed_next = 1'b1;
                end
                crc_next     = crc_upd;
                tlv_ctl.step = 1'b1;
                count_next   = count_reg + LEN_W'(1);
                if (count_next >= plen_reg)
                begin
                    res_next.frame_end    = 1'b1;
                    res_next.frame_length = 10'(plen_reg);
                    if (crc_upd != exp_crc_reg)
                    begin
                        res_next.frame_status = ST_CRC_ERR;
                    end
                    else if (fixed_next && (32'(plen_reg) >= FIXED_MIN_LEN))
                    begin
                        res_next.frame_status = ST_FIXED;
                    end
                    else if (tlv_seen)
                    begin
                        res_next.frame_status  = ST_LEGACY;
                        res_next.unknown_items = tlv_tally;
                    end
                    else
                    begin
                        res_next.frame_status = ST_UNKNOWN;
                    end
                    phase_next = PH_SYNC1;
                end
            end
            default:
            begin
                phase_next = PH_SYNC1;
            end
        endcase
        if (!accept)
        begin
            tlv_ctl.clear = 1'b0;
            tlv_ctl.step  = 1'b0;
        end
        if (!res_next.frame_end &&
            (phase_next == PH_CRCLO || phase_next == PH_CRCHI || phase_next == PH_PAYLOAD))
        begin
            res_next.frame_length = 10'(plen_next);
        end
        res_next.frame_phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC1;
            len_lo_reg    <= '0;
            plen_reg      <= '0;
            exp_crc_reg   <= '0;
            crc_reg       <= '0;
            count_reg     <= '0;
            fixed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                len_lo_reg  <= len_lo_next;
                plen_reg    <= plen_next;
                exp_crc_reg <= exp_crc_next;
                crc_reg     <= crc_next;
                count_reg   <= count_next;
                fixed_reg   <= fixed_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign dout.valid         = out_valid_reg;
    assign dout.frame_phase   = res_reg.frame_phase;
    assign dout.payload_valid = res_reg.payload_valid;
    assign dout.payload_byte  = res_reg.payload_byte;
    assign dout.byte_offset   = res_reg.byte_offset;
    assign dout.frame_end     = res_reg.frame_end;
    assign dout.frame_status  = res_reg.frame_status;
    assign dout.frame_length  = res_reg.frame_length;
    assign dout.sync_found    = res_reg.sync_found;
    assign dout.unknown_items = res_reg.unknown_items;

endmodule

FILE: sv/ifd_checker.sv
module ifd_checker
    import ifd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] frame_phase,
    input logic       payload_valid,
    input logic       frame_end,
    input logic [2:0] frame_status,
    input logic       sync_found,
    input logic [9:0] unknown_items
);

    // a pending result is never dropped while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");

    // a verdict always sends the deframer back to sync hunt
    a_end_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> frame_phase == PH_SYNC1)
        else $error("verdict without return to sync hunt");

    // payload items stay in payload phase unless they close the frame
    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> frame_phase == PH_PAYLOAD || frame_end)
        else $error("payload item outside payload phase");

    // unknown count only reported with a good legacy verdict
    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unknown_items != 10'd0 |-> frame_end && frame_status == ST_LEGACY)
        else $error("unknown count without legacy verdict");

    // completed sync leads straight into the length field
    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sync_found |-> frame_phase == PH_LENLO && !payload_valid)
        else $error("sync flag with wrong phase");

endmodule

bind imu_frame_deframer_crc16 ifd_checker u_ifd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .frame_phase   (dout.frame_phase),
    .payload_valid (dout.payload_valid),
    .frame_end     (dout.frame_end),
    .frame_status  (dout.frame_status),
    .sync_found    (dout.sync_found),
    .unknown_items (dout.unknown_items)
);

FILE: test/imu_frame_deframer_crc16_test.sv
module imu_frame_deframer_crc16_test;
    import ifd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] TAG_PAIR = 8'h90;
    localparam logic [7:0] TAG_WIDE = 8'hD9;
    localparam logic [7:0] TAG_LONG = 8'hD1;
    localparam logic [7:0] TAG_SEVEN [11] = '{8'hA0, 8'hA1, 8'hA2, 8'hA5, 8'hB0, 8'hB1,
                                              8'hB2, 8'hC0, 8'hC1, 8'hC2, 8'hD0};
    localparam logic [7:0] TAG_BARE [2] = '{8'hE0, 8'hF0};

    class frame_tracker;
        phase_t      phase;
        logic [7:0]  len_lo;
        logic [9:0]  frame_len;
        logic [15:0] want_crc;
        logic [15:0] crc_acc;
        logic [9:0]  offset_cnt;
        bit          fixed_hit;
        logic [4:0]  item_left;
        bit          item_data;
        bit          data_item_done;
        logic [9:0]  unk_tally;
        result_t     due_results[$];
        int          errors;
        int          reported;

        function new();
            phase = PH_SYNC1;
            len_lo = '0;
            frame_len = '0;
            want_crc = '0;
            crc_acc = '0;
            offset_cnt = '0;
            fixed_hit = 1'b0;
            item_left = '0;
            item_data = 1'b0;
            data_item_done = 1'b0;
            unk_tally = '0;
            errors = 0;
            reported = 0;
        endfunction

        static function logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] acc;
            acc = c ^ {b, 8'h00};
            repeat (8)
            begin
                if (acc[15])
                    acc = (acc << 1) ^ 16'h1021;
                else
                    acc = acc << 1;
            end
            return acc;
        endfunction

        // item length in bytes, 0 for an unknown tag
        static function int tlv_span(input logic [7:0] tag, output bit carries);
            carries = 1'b1;
            if (tag == TAG_PAIR)
                return 2;
            if (tag == TAG_WIDE)
                return 13;
            if (tag == TAG_LONG)
                return 17;
            foreach (TAG_SEVEN[i])
                if (tag == TAG_SEVEN[i])
                    return 7;
            carries = 1'b0;
            foreach (TAG_BARE[i])
                if (tag == TAG_BARE[i])
                    return 5;
            return 0;
        endfunction

        function void predict_byte(input logic [7:0] b);
            result_t     r;
            logic [15:0] len16;
            int          span;
            bit          carries;
            r = '0;
            case (phase)
                PH_SYNC1:
                begin
                    if (b == SYNC_A)
                        phase = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    if (b == SYNC_B)
                    begin
                        r.sync_found = 1'b1;
                        crc_acc = crc_next(crc_next(16'h0000, SYNC_A), SYNC_B);
                        phase = PH_LENLO;
                    end
                    else if (b != SYNC_A)
                    begin
                        phase = PH_SYNC1;
                    end
                end
                PH_LENLO:
                begin
                    len_lo = b;
                    crc_acc = crc_next(crc_acc, b);
                    phase = PH_LENHI;
                end
                PH_LENHI:
                begin
                    len16 = {b, len_lo};
                    if (len16 == 0 || len16 > MAX_PAYLOAD_DEF)
                    begin
                        r.frame_end = 1'b1;
                        r.frame_status = ST_LEN_ERR;
                        r.frame_length = (len16 > 16'd1023) ? TALLY_MAX : len16[9:0];
                        phase = PH_SYNC1;
                    end
                    else
                    begin
                        frame_len = len16[9:0];
                        crc_acc = crc_next(crc_acc, b);
                        phase = PH_CRCLO;
                    end
                end
                PH_CRCLO:
                begin
                    want_crc = {8'h00, b};
                    phase = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    want_crc[15:8] = b;
                    offset_cnt = '0;
                    fixed_hit = 1'b0;
                    item_left = '0;
                    item_data = 1'b0;
                    data_item_done = 1'b0;
                    unk_tally = '0;
                    phase = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = b;
                    r.byte_offset = offset_cnt[8:0];
                    if (offset_cnt == 0 && b == FIXED_TAG)
                        fixed_hit = 1'b1;
                    crc_acc = crc_next(crc_acc, b);
                    if (item_left == 0)
                    begin
                        span = tlv_span(b, carries);
                        if (span == 0)
                        begin
                            if (unk_tally != TALLY_MAX)
                                unk_tally++;
                        end
                        else
                        begin
                            item_left = 5'(span - 1);
                            item_data = carries;
                        end
                    end
                    else
                    begin
                        item_left--;
                        if (item_left == 0 && item_data)
                            data_item_done = 1'b1;
                    end
                    offset_cnt++;
                    if (offset_cnt >= frame_len)
                    begin
                        r.frame_end = 1'b1;
                        r.frame_length = frame_len;
                        if (crc_acc != want_crc)
                            r.frame_status = ST_CRC_ERR;
                        else if (fixed_hit && frame_len >= FIXED_MIN_LEN)
                            r.frame_status = ST_FIXED;
                        else if (data_item_done)
                        begin
                            r.frame_status = ST_LEGACY;
                            r.unknown_items = unk_tally;
                        end
                        else
                            r.frame_status = ST_UNKNOWN;
                        phase = PH_SYNC1;
                    end
                end
                default:
                begin
                    phase = PH_SYNC1;
                end
            endcase
            if ((phase == PH_CRCLO || phase == PH_CRCHI || phase == PH_PAYLOAD)
                && !r.frame_end)
                r.frame_length = frame_len;
            r.frame_phase = phase;
            due_results.push_back(r);
        endfunction

        function void flag(input string name, input logic [15:0] want, input logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                if (reported < 10)
                    $display("mismatch on %s: expected %0d, got %0d", name, want, got);
                reported++;
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                if (reported < 10)
                    $display("result item with nothing expected: phase %0d", got.frame_phase);
                reported++;
                return;
            end
            want = due_results.pop_front();
            flag("frame_phase", want.frame_phase, got.frame_phase);
            flag("payload_valid", want.payload_valid, got.payload_valid);
            flag("payload_byte", want.payload_byte, got.payload_byte);
            flag("byte_offset", want.byte_offset, got.byte_offset);
            flag("frame_end", want.frame_end, got.frame_end);
            flag("frame_status", want.frame_status, got.frame_status);
            flag("frame_length", want.frame_length, got.frame_length);
            flag("sync_found", want.sync_found, got.sync_found);
            flag("unknown_items", want.unknown_items, got.unknown_items);
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   gaps_on = 1'b1;
    int   sent_bytes = 0;
    logic [7:0] body[$];

    frame_tracker tracker = new();

    ifd_in_if  din_if();
    ifd_out_if dout_if();

    imu_frame_deframer_crc16 i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
            tracker.check_result(result_t'{dout_if.frame_phase, dout_if.payload_valid,
                dout_if.payload_byte, dout_if.byte_offset, dout_if.frame_end,
                dout_if.frame_status, dout_if.frame_length, dout_if.sync_found,
                dout_if.unknown_items});
    end

    // receiver stalls
    initial
    begin
        dout_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (gaps_on && $urandom_range(0, 6) == 0)
            begin
                dout_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            dout_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            din_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.rx_byte <= b;
        do
            @(posedge clk);
        while (din_if.ready !== 1'b1);
        tracker.predict_byte(b);
        sent_bytes++;
    endtask

    task automatic send_header(input logic [15:0] len16, input int extra_a);
        repeat (extra_a) send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(len16[7:0]);
        send_byte(len16[15:8]);
    endtask

    task automatic send_frame(input bit corrupt, input int extra_a);
        logic [15:0] len16;
        logic [15:0] crc;
        len16 = 16'(body.size());
        crc = frame_tracker::crc_next(frame_tracker::crc_next(16'h0000, SYNC_A), SYNC_B);
        crc = frame_tracker::crc_next(crc, len16[7:0]);
        crc = frame_tracker::crc_next(crc, len16[15:8]);
        foreach (body[i])
            crc = frame_tracker::crc_next(crc, body[i]);
        if (corrupt)
            crc ^= 16'($urandom_range(1, 65535));
        send_header(len16, extra_a);
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        foreach (body[i])
            send_byte(body[i]);
    endtask

    function automatic void fill_random(input int n);
        body.delete();
        repeat (n) body.push_back(8'($urandom));
    endfunction

    function automatic void fill_fixed(input int n);
        fill_random(n);
        body[0] = FIXED_TAG;
    endfunction

    // items of known and random tags with random content, cut to n bytes
    function automatic void fill_tlv(input int n);
        logic [7:0] tag;
        int         pick;
        int         span;
        bit         carries;
        body.delete();
        while (body.size() < n)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 11)
                tag = TAG_SEVEN[pick];
            else if (pick == 11)
                tag = TAG_PAIR;
            else if (pick == 12)
                tag = TAG_WIDE;
            else if (pick == 13)
                tag = TAG_LONG;
            else if (pick < 16)
                tag = TAG_BARE[pick - 14];
            else
                tag = 8'($urandom);
            body.push_back(tag);
            span = frame_tracker::tlv_span(tag, carries);
            for (int k = 1; k < span; k++)
                body.push_back(8'($urandom));
        end
        while (body.size() > n)
            void'(body.pop_back());
    endfunction

    task automatic run_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_B);
        send_byte(SYNC_A);
        send_byte(8'h00);
        // length errors, saturated above 1023
        send_header(16'd0, 0);
        send_header(16'd513, 1);
        send_header(16'hFFFF, 0);
        send_header(16'h0400, 0);
        fill_fixed(76);
        send_frame(1'b0, 0);
        fill_fixed(75);
        send_frame(1'b0, 0);
        fill_fixed(76);
        send_frame(1'b1, 0);
        // one item of every known tag
        body.delete();
        foreach (TAG_SEVEN[i])
        begin
            body.push_back(TAG_SEVEN[i]);
            repeat (6) body.push_back(8'($urandom));
        end
        body.push_back(TAG_PAIR);
        body.push_back(8'($urandom));
        body.push_back(TAG_WIDE);
        repeat (12) body.push_back(8'($urandom));
        body.push_back(TAG_LONG);
        repeat (16) body.push_back(8'($urandom));
        foreach (TAG_BARE[i])
        begin
            body.push_back(TAG_BARE[i]);
            repeat (4) body.push_back(8'($urandom));
        end
        send_frame(1'b0, 0);
        body = '{8'h00, 8'h33, TAG_PAIR, 8'h12};
        send_frame(1'b0, 0);
        body = '{TAG_BARE[0], 8'h01, 8'h02, 8'h03, 8'h04};
        send_frame(1'b0, 0);
        // data item cut short by the payload end
        body = '{TAG_LONG, 8'h01, 8'h02, 8'h03, 8'h04};
        send_frame(1'b0, 0);
        fill_random(1);
        send_frame(1'b0, 0);
        fill_tlv(20);
        send_frame(1'b0, 3);
        fill_tlv(512);
        send_frame(1'b0, 0);
        fill_tlv(30);
        send_frame(1'b1, 0);
    endtask

    task automatic run_random();
        int pick;
        int kind;
        int len;
        bit corrupt;
        int extra_a;
        while (sent_bytes < 1950)
        begin
            gaps_on = (sent_bytes < 1700);
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
            end
            else if (pick < 14)
            begin
                send_byte(SYNC_A);
                send_byte(8'($urandom_range(0, 1) ? 8'h00 : 8'h5B));
            end
            else if (pick < 20)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_header(16'd0, 0);
                else
                    send_header(16'($urandom_range(513, 65535)), 0);
            end
            else
            begin
                kind = $urandom_range(0, 9);
                corrupt = ($urandom_range(0, 6) == 0);
                extra_a = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
                if ($urandom_range(0, 29) == 0)
                    len = $urandom_range(76, 300);
                else
                    len = $urandom_range(1, 40);
                if (kind < 3)
                    fill_fixed($urandom_range(70, 110));
                else if (kind < 8)
                    fill_tlv(len);
                else
                    fill_random(len);
                send_frame(corrupt, extra_a);
            end
        end
    endtask

    initial
    begin
        int guard;
        rst_n <= 1'b0;
        din_if.valid <= 1'b0;
        din_if.rx_byte <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        din_if.valid <= 1'b0;
        guard = 0;
        while (tracker.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        tracker.errors += tracker.pending();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
